// ===== rtl/stts_pkg.sv =====
// ----------------------------------------------------------------------------
// stts_pkg
// Shared types and constants for the staged thermostat scheduler.
// ----------------------------------------------------------------------------
package stts_pkg;

    typedef enum logic [1:0] {
        MODE_OFF       = 2'd0,
        MODE_BAND_LOW  = 2'd1,
        MODE_SCHED     = 2'd2,
        MODE_BAND_HIGH = 2'd3
    } mode_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SP_ONE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SP_TWO     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SP_THREE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SP_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_STARTS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_STOPS  = 3'd6;

    localparam logic signed [7:0] SP_LIMIT_RESET = 8'sd127;

    // status flag bits
    localparam logic [2:0] FLAG_NONE = 3'b000;
    localparam logic [2:0] FLAG_KEEP = 3'b001;
    localparam logic [2:0] FLAG_HEAT = 3'b010;
    localparam logic [2:0] FLAG_FAN  = 3'b100;

    // stage relay bits
    localparam logic [2:0] STAGE_NONE = 3'b000;
    localparam logic [2:0] STAGE_LOW  = 3'b001;
    localparam logic [2:0] STAGE_MID  = 3'b010;
    localparam logic [2:0] STAGE_HIGH = 3'b100;

    localparam logic [3:0] PWR_OFF  = 4'd0;
    localparam logic [3:0] PWR_LOW  = 4'd2;
    localparam logic [3:0] PWR_MID  = 4'd5;
    localparam logic [3:0] PWR_HIGH = 4'd8;

    // band edges, widened to hold any setpoint minus temperature
    localparam logic signed [8:0] BAND_BASE_LOW  = 9'sd5;
    localparam logic signed [8:0] BAND_BASE_HIGH = 9'sd10;
    localparam logic signed [8:0] BAND_STEP      = 9'sd5;

    localparam logic signed [8:0] SCHED_EDGE_ONE   = 9'sd5;
    localparam logic signed [8:0] SCHED_EDGE_TWO   = 9'sd10;
    localparam logic signed [8:0] SCHED_EDGE_THREE = 9'sd15;

    localparam logic [5:0] HOUR_BCD_TENS = 6'd10;
    localparam logic [5:0] HOUR_BCD_HIGH = 6'd32;
    localparam logic [5:0] HOUR_ADJ_ONE  = 6'd6;
    localparam logic [5:0] HOUR_ADJ_TWO  = 6'd12;

    typedef struct packed {
        mode_t              mode;
        logic signed [7:0]  sp_one;
        logic signed [7:0]  sp_two;
        logic signed [7:0]  sp_three;
        logic signed [7:0]  sp_limit;
        logic [23:0]        starts;
        logic [23:0]        stops;
    } cfg_t;

    typedef struct packed {
        logic               main_on;
        logic [2:0]         stages;
        logic [2:0]         flags;
        logic [3:0]         power;
        logic [1:0]         win;
        logic               in_window;
    } result_t;

endpackage

// ===== rtl/stts_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// stts_cfg_regs
// Configuration register file written through the config request channel.
// ----------------------------------------------------------------------------
module stts_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [stts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stts_pkg::CFG_DATA_W-1:0]   cfg_data,
    output stts_pkg::cfg_t                    cfg
);
    import stts_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:       cfg_next.mode     = mode_t'(cfg_data[1:0]);
                REG_SP_ONE:     cfg_next.sp_one   = cfg_data[7:0];
                REG_SP_TWO:     cfg_next.sp_two   = cfg_data[7:0];
                REG_SP_THREE:   cfg_next.sp_three = cfg_data[7:0];
                REG_SP_LIMIT:   cfg_next.sp_limit = cfg_data[7:0];
                REG_WIN_STARTS: cfg_next.starts   = cfg_data[23:0];
                REG_WIN_STOPS:  cfg_next.stops    = cfg_data[23:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode     <= MODE_OFF;
            cfg_reg.sp_one   <= 8'sd0;
            cfg_reg.sp_two   <= 8'sd0;
            cfg_reg.sp_three <= 8'sd0;
            cfg_reg.sp_limit <= SP_LIMIT_RESET;
            cfg_reg.starts   <= 24'd0;
            cfg_reg.stops    <= 24'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/stts_window_scan.sv =====
// ----------------------------------------------------------------------------
// stts_window_scan
// Checks the three hour windows in parallel and picks the reported window.
// ----------------------------------------------------------------------------
module stts_window_scan (
    input  logic [5:0]  hour_bin,
    input  logic [23:0] starts,
    input  logic [23:0] stops,
    input  logic [1:0]  win_cur,
    output logic [1:0]  win_next,
    output logic        in_window
);
    import stts_pkg::*;

    // returns {active, ready}
    function automatic logic [1:0] check_window(
        input logic [7:0] start,
        input logic [7:0] stop,
        input logic [7:0] prev,
        input logic [7:0] hr
    );
        logic       active;
        logic       ready;
        logic [7:0] top;
        if (stop < start)
        begin
            active = !(hr >= stop && hr < start);
            top    = start;
        end
        else
        begin
            active = hr >= start && hr < stop;
            top    = stop;
        end
        if (top < prev)
            ready = !(hr >= top && hr < prev);
        else
            ready = hr >= prev && hr < top;
        return {active, ready};
    endfunction

    logic [7:0] hr;
    logic [1:0] chk1;
    logic [1:0] chk2;
    logic [1:0] chk3;

    assign hr   = {2'b00, hour_bin};
    assign chk1 = check_window(starts[7:0],   stops[7:0],   stops[23:16], hr);
    assign chk2 = check_window(starts[15:8],  stops[15:8],  stops[7:0],   hr);
    assign chk3 = check_window(starts[23:16], stops[23:16], stops[15:8],  hr);

    // scan ends at the first active window; later windows are not looked at
    always_comb
    begin
        win_next = win_cur;
        if (chk1[0])
            win_next = 2'd1;
        if (!chk1[1] && chk2[0])
            win_next = 2'd2;
        if (!chk1[1] && !chk2[1] && chk3[0])
            win_next = 2'd3;
        in_window = chk1[1] | chk2[1] | chk3[1];
    end

endmodule

// ===== rtl/stts_core.sv =====
// ----------------------------------------------------------------------------
// stts_core
// Controller state and single-pass next-state logic for band and schedule modes.
// ----------------------------------------------------------------------------
module stts_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  stts_pkg::cfg_t          cfg,
    input  logic signed [7:0]       temp,
    input  logic [5:0]              hour_bcd,
    output stts_pkg::result_t       result
);
    import stts_pkg::*;

    logic [2:0]        stages_reg;
    logic [2:0]        stages_next;
    logic [2:0]        flags_reg;
    logic [2:0]        flags_next;
    logic [3:0]        power_reg;
    logic [3:0]        power_next;
    logic [1:0]        win_reg;
    logic [1:0]        win_next;
    logic signed [7:0] held_reg;
    logic signed [7:0] held_next;

    logic [5:0]        hour_bin;
    logic [1:0]        win_scan;
    logic              in_window;
    logic signed [8:0] band_diff;
    logic signed [8:0] sched_diff;
    logic signed [8:0] edge_lo;
    logic signed [8:0] edge_mid;
    logic signed [8:0] edge_hi;

    always_comb
    begin
        if (hour_bcd < HOUR_BCD_TENS)
            hour_bin = hour_bcd;
        else if (hour_bcd < HOUR_BCD_HIGH)
            hour_bin = hour_bcd - HOUR_ADJ_ONE;
        else
            hour_bin = hour_bcd - HOUR_ADJ_TWO;
    end

    stts_window_scan u_scan (
        .hour_bin  (hour_bin),
        .starts    (cfg.starts),
        .stops     (cfg.stops),
        .win_cur   (win_reg),
        .win_next  (win_scan),
        .in_window (in_window)
    );

    assign edge_lo   = (cfg.mode == MODE_BAND_HIGH) ? BAND_BASE_HIGH : BAND_BASE_LOW;
    assign edge_mid  = edge_lo + BAND_STEP;
    assign edge_hi   = edge_mid + BAND_STEP;
    assign band_diff = {cfg.sp_one[7], cfg.sp_one} - {temp[7], temp};

    always_comb
    begin
        priority if (win_scan == 2'd1)
            held_next = cfg.sp_one;
        else if (win_scan == 2'd2)
            held_next = cfg.sp_two;
        else if (win_scan == 2'd3)
            held_next = cfg.sp_three;
        else
            held_next = held_reg;
    end

    assign sched_diff = {held_next[7], held_next} - {temp[7], temp};

    always_comb
    begin
        stages_next      = stages_reg;
        flags_next       = flags_reg;
        power_next       = power_reg;
        win_next         = win_reg;
        result.main_on   = 1'b1;
        result.in_window = 1'b0;
        unique case (cfg.mode)
            MODE_OFF:
            begin
                stages_next    = STAGE_NONE;
                flags_next     = FLAG_NONE;
                power_next     = PWR_OFF;
                result.main_on = 1'b0;
            end
            MODE_SCHED:
            begin
                win_next         = win_scan;
                result.in_window = in_window;
                priority if (!in_window)
                begin
                    stages_next = STAGE_NONE;
                    flags_next  = FLAG_FAN;
                    power_next  = PWR_OFF;
                end
                else if (sched_diff < SCHED_EDGE_ONE)
                begin
                    stages_next = STAGE_NONE;
                    flags_next  = FLAG_KEEP | FLAG_FAN;
                    power_next  = PWR_LOW;
                end
                else if (sched_diff < SCHED_EDGE_TWO)
                begin
                    stages_next = STAGE_LOW;
                    flags_next  = FLAG_KEEP | FLAG_FAN;
                    power_next  = PWR_LOW;
                end
                else if (sched_diff < SCHED_EDGE_THREE)
                begin
                    stages_next = STAGE_LOW | STAGE_MID;
                    flags_next  = FLAG_HEAT | FLAG_FAN;
                    power_next  = PWR_MID;
                end
                else
                begin
                    stages_next = STAGE_LOW | STAGE_MID | STAGE_HIGH;
                    flags_next  = FLAG_HEAT | FLAG_FAN;
                    power_next  = PWR_HIGH;
                end
            end
            MODE_BAND_LOW, MODE_BAND_HIGH:
            begin
                // off condition wins over every band; small differences hold
                priority if (band_diff <= 9'sd0 || cfg.sp_one > cfg.sp_limit)
                begin
                    stages_next = STAGE_NONE;
                    flags_next  = FLAG_KEEP | FLAG_FAN;
                    power_next  = PWR_OFF;
                end
                else if (band_diff > edge_hi)
                begin
                    stages_next = stages_reg | STAGE_HIGH;
                    flags_next  = FLAG_HEAT | FLAG_FAN;
                    power_next  = PWR_HIGH;
                end
                else if (band_diff > edge_mid)
                begin
                    stages_next = stages_reg | STAGE_MID;
                    flags_next  = FLAG_HEAT | FLAG_FAN;
                    power_next  = PWR_MID;
                end
                else if (band_diff >= edge_lo)
                begin
                    stages_next = stages_reg | STAGE_LOW;
                    flags_next  = FLAG_KEEP | FLAG_FAN;
                    power_next  = PWR_LOW;
                end
                else
                begin
                    stages_next = stages_reg;
                end
            end
            default:
            begin
                stages_next = stages_reg;
            end
        endcase
        result.stages = stages_next;
        result.flags  = flags_next;
        result.power  = power_next;
        result.win    = win_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stages_reg <= STAGE_NONE;
            flags_reg  <= FLAG_NONE;
            power_reg  <= PWR_OFF;
            win_reg    <= 2'd0;
            held_reg   <= 8'sd0;
        end
        else if (advance)
        begin
            stages_reg <= stages_next;
            flags_reg  <= flags_next;
            power_reg  <= power_next;
            win_reg    <= win_next;
            if (cfg.mode == MODE_SCHED)
                held_reg <= held_next;
        end
    end

endmodule

// ===== rtl/staged_thermostat_scheduler.sv =====
// ----------------------------------------------------------------------------
// staged_thermostat_scheduler
// Staged heater controller with band modes and a three-window hour schedule.
// ----------------------------------------------------------------------------
// usage:
//   input channel: in_valid / in_stall with measured_temp and hour_bcd, one
//   request per control tick. output channel: out_valid / out_stall with the
//   relay, flag, power and window fields, exactly one result per request.
//   config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high, indexes past the register list are ignored.
//   write config only while no request is in flight.
// pipeline: input register, then result register; out_valid rises as the
//   result loads. throughput: one request per cycle while out_stall is low;
//   the state feedback (stage relays, flags, power, window, held setpoint)
//   is registered in the core and updated with each result.
// stall: a stalled result holds in the result register; one more request
//   waits in the input register, after that in_stall rises.
// reset: mode off, setpoints zero, limit 127, windows zero, all relays and
//   flags off, no window selected, both pipeline registers empty.
// ----------------------------------------------------------------------------
module staged_thermostat_scheduler (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [stts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stts_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [7:0]                 measured_temp,
    input  logic [5:0]                        hour_bcd,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              relay_main,
    output logic                              relay_low,
    output logic                              relay_mid,
    output logic                              relay_high,
    output logic                              keep_warm,
    output logic                              heating,
    output logic [3:0]                        power_level,
    output logic                              fan_on,
    output logic [1:0]                        window_index,
    output logic                              in_window
);
    import stts_pkg::*;

    cfg_t              cfg;
    result_t           result;
    result_t           out_reg;
    logic              in_valid_reg;
    logic              in_valid_next;
    logic signed [7:0] temp_reg;
    logic [5:0]        hour_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_ready;
    logic              accept;
    logic              advance;

    stts_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    stts_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .cfg      (cfg),
        .temp     (temp_reg),
        .hour_bcd (hour_reg),
        .result   (result)
    );

    assign out_ready = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_ready;
    assign in_stall  = in_valid_reg && !out_ready;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            temp_reg <= measured_temp;
            hour_reg <= hour_bcd;
        end
        if (advance)
            out_reg <= result;
    end

    assign out_valid    = out_valid_reg;
    assign relay_main   = out_reg.main_on;
    assign relay_low    = out_reg.stages[0];
    assign relay_mid    = out_reg.stages[1];
    assign relay_high   = out_reg.stages[2];
    assign keep_warm    = out_reg.flags[0];
    assign heating      = out_reg.flags[1];
    assign fan_on       = out_reg.flags[2];
    assign power_level  = out_reg.power;
    assign window_index = out_reg.win;
    assign in_window    = out_reg.in_window;

endmodule

// ===== tb/staged_thermostat_scheduler_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// staged_thermostat_scheduler_tb
// Drives temperature and hour requests through both band modes, the schedule
// mode and off, with bursty input and an irregular output stall. The expected
// relay, flag, power and window fields come from a behavioral copy of the
// heater state kept in this bench, and every result is checked against it.
// ----------------------------------------------------------------------------
module staged_thermostat_scheduler_tb;
    import stts_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 1200;

    typedef struct packed {
        logic signed [7:0] temp;
        logic [5:0]        hour;
    } sample_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic signed [7:0]      measured_temp = '0;
    logic [5:0]             hour_bcd = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   relay_main;
    logic                   relay_low;
    logic                   relay_mid;
    logic                   relay_high;
    logic                   keep_warm;
    logic                   heating;
    logic [3:0]             power_level;
    logic                   fan_on;
    logic [1:0]             window_index;
    logic                   in_window;

    // configuration as the block should hold it
    mode_t                  cfg_mode = MODE_OFF;
    logic signed [7:0]      win_sp [3];
    logic signed [7:0]      cfg_limit = SP_LIMIT_RESET;
    logic [23:0]            cfg_starts = '0;
    logic [23:0]            cfg_stops = '0;

    // heater state as the block should hold it
    logic [2:0]             heat_stages = STAGE_NONE;
    logic [2:0]             heat_flags = FLAG_NONE;
    logic [3:0]             heat_power = PWR_OFF;
    logic [1:0]             sched_win = '0;
    logic signed [7:0]      sched_sp = '0;

    sample_t                sample_q [$];
    result_t                result_due [$];
    int                     items_queued = 0;
    int                     items_taken = 0;
    int                     fault_count = 0;
    logic                   in_fire = 1'b0;
    int                     burst_left = 0;
    int                     gap_left = 0;
    int                     hold_asked = 0;
    int                     hold_served = 0;
    int                     hold_cnt = 0;
    int                     seg_left = 0;
    int                     stall_style = 0;
    int                     quiet_cycles = 0;

    staged_thermostat_scheduler u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .measured_temp (measured_temp),
        .hour_bcd      (hour_bcd),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .relay_main    (relay_main),
        .relay_low     (relay_low),
        .relay_mid     (relay_mid),
        .relay_high    (relay_high),
        .keep_warm     (keep_warm),
        .heating       (heating),
        .power_level   (power_level),
        .fan_on        (fan_on),
        .window_index  (window_index),
        .in_window     (in_window)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        win_sp[0] = '0;
        win_sp[1] = '0;
        win_sp[2] = '0;
    end

    function automatic void hold_outputs(logic [2:0] stages, logic [2:0] flags,
                                         logic [3:0] power);
        heat_stages = stages;
        heat_flags  = flags;
        heat_power  = power;
    endfunction

    function automatic result_t thermo_predict(logic signed [7:0] temp, logic [5:0] hbcd);
        result_t r;
        int t, h, sp, lim, d, base, st, so, pv, top, i;
        bit active;
        bit ready;
        t = temp;
        h = hbcd;
        if (h >= 32)
            h = h - 12;
        else if (h >= 10)
            h = h - 6;
        active = 1'b0;
        ready = 1'b0;
        case (cfg_mode)
            MODE_BAND_LOW, MODE_BAND_HIGH:
            begin
                base = (cfg_mode == MODE_BAND_LOW) ? 5 : 10;
                sp = win_sp[0];
                lim = cfg_limit;
                d = sp - t;
                // each band adds its own relay, earlier ones stay latched
                if (d >= base && d <= base + 5)
                    hold_outputs(heat_stages | STAGE_LOW, FLAG_KEEP | FLAG_FAN, PWR_LOW);
                if (d > base + 5 && d <= base + 10)
                    hold_outputs(heat_stages | STAGE_MID, FLAG_HEAT | FLAG_FAN, PWR_MID);
                if (d > base + 10)
                    hold_outputs(heat_stages | STAGE_HIGH, FLAG_HEAT | FLAG_FAN, PWR_HIGH);
                if (d <= 0 || sp > lim)
                    hold_outputs(STAGE_NONE, FLAG_KEEP | FLAG_FAN, PWR_OFF);
            end
            MODE_SCHED:
            begin
                for (i = 0; i < 3 && !active; i++)
                begin
                    st = cfg_starts[8*i +: 8];
                    so = cfg_stops[8*i +: 8];
                    pv = cfg_stops[8*((i + 2) % 3) +: 8];
                    if (so < st)
                    begin
                        active = !(h >= so && h < st);
                        top = st;
                    end
                    else
                    begin
                        active = (h >= st && h < so);
                        top = so;
                    end
                    // readiness uses the larger bound against the previous stop
                    if (top < pv)
                        ready = !(h >= top && h < pv);
                    else
                        ready = (h >= pv && h < top);
                    if (ready)
                        sched_win = 2'(i + 1);
                end
                if (sched_win != 2'd0)
                    sched_sp = win_sp[sched_win - 1];
                if (!active)
                    hold_outputs(STAGE_NONE, FLAG_FAN, PWR_OFF);
                else
                begin
                    d = sched_sp - t;
                    if (d < 5)
                        hold_outputs(STAGE_NONE, FLAG_KEEP | FLAG_FAN, PWR_LOW);
                    else if (d < 10)
                        hold_outputs(STAGE_LOW, FLAG_KEEP | FLAG_FAN, PWR_LOW);
                    else if (d < 15)
                        hold_outputs(STAGE_LOW | STAGE_MID, FLAG_HEAT | FLAG_FAN, PWR_MID);
                    else
                        hold_outputs(STAGE_LOW | STAGE_MID | STAGE_HIGH, FLAG_HEAT | FLAG_FAN,
                                     PWR_HIGH);
                end
            end
            default:
                hold_outputs(STAGE_NONE, FLAG_NONE, PWR_OFF);
        endcase
        r.main_on   = (cfg_mode != MODE_OFF);
        r.stages    = heat_stages;
        r.flags     = heat_flags;
        r.power     = heat_power;
        r.win       = sched_win;
        r.in_window = (cfg_mode == MODE_SCHED) && active;
        return r;
    endfunction

    function automatic string result_text(result_t r);
        return $sformatf({"main=%0b low=%0b mid=%0b high=%0b keep=%0b heat=%0b",
                          " pwr=%0d fan=%0b win=%0d inw=%0b"},
                         r.main_on, r.stages[0], r.stages[1], r.stages[2], r.flags[0],
                         r.flags[1], r.power, r.flags[2], r.win, r.in_window);
    endfunction

    function automatic string result_diff(result_t w, result_t g);
        string s;
        s = "";
        if (w.main_on !== g.main_on)     s = {s, " relay_main"};
        if (w.stages[0] !== g.stages[0]) s = {s, " relay_low"};
        if (w.stages[1] !== g.stages[1]) s = {s, " relay_mid"};
        if (w.stages[2] !== g.stages[2]) s = {s, " relay_high"};
        if (w.flags[0] !== g.flags[0])   s = {s, " keep_warm"};
        if (w.flags[1] !== g.flags[1])   s = {s, " heating"};
        if (w.power !== g.power)         s = {s, " power_level"};
        if (w.flags[2] !== g.flags[2])   s = {s, " fan_on"};
        if (w.win !== g.win)             s = {s, " window_index"};
        if (w.in_window !== g.in_window) s = {s, " in_window"};
        return s;
    endfunction

    function automatic logic [5:0] bcd_hour(int hr);
        return 6'(((hr / 10) << 4) | (hr % 10));
    endfunction

    // keeps the register bits, fills the unused upper data bits with noise
    function automatic logic [23:0] noisy(int v, int w);
        logic [23:0] m;
        m = (24'd1 << w) - 24'd1;
        return (24'($urandom) & ~m) | (24'(v) & m);
    endfunction

    // request driver
    always @(negedge clk)
    begin : drive_requests
        sample_t s;
        if (!in_valid || in_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (sample_q.size() > 0)
            begin
                s = sample_q.pop_front();
                measured_temp <= s.temp;
                hour_bcd <= s.hour;
                in_valid <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // request capture and prediction
    always @(posedge clk)
    begin
        in_fire <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            result_due.push_back(thermo_predict(measured_temp, hour_bcd));
            items_taken++;
        end
    end

    // result stall pattern
    always @(negedge clk)
    begin
        if (hold_served != hold_asked && hold_cnt == 0)
        begin
            hold_cnt = LONG_HOLD_CYCLES;
            hold_served++;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(16, 96);
                stall_style = $urandom_range(0, 3);
            end
            seg_left--;
            case (stall_style)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 25);
                2: out_stall <= ($urandom_range(0, 99) < 70);
                default: out_stall <= (seg_left % 3 == 0);
            endcase
        end
    end

    // result monitor
    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        string bad;
        if (rst_n && out_valid && !out_stall)
        begin
            got.main_on   = relay_main;
            got.stages    = {relay_high, relay_mid, relay_low};
            got.flags     = {fan_on, heating, keep_warm};
            got.power     = power_level;
            got.win       = window_index;
            got.in_window = in_window;
            if (result_due.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result at %0t: %s", $realtime, result_text(got));
            end
            else
            begin
                want = result_due.pop_front();
                bad = result_diff(want, got);
                if (bad != "")
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("mismatch at %0t on%s\n  exp %s\n  got %s", $realtime, bad,
                                 result_text(want), result_text(got));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("staged_thermostat_scheduler_tb: done, errors");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_MODE:       cfg_mode = mode_t'(data[1:0]);
            REG_SP_ONE:     win_sp[0] = data[7:0];
            REG_SP_TWO:     win_sp[1] = data[7:0];
            REG_SP_THREE:   win_sp[2] = data[7:0];
            REG_SP_LIMIT:   cfg_limit = data[7:0];
            REG_WIN_STARTS: cfg_starts = data;
            REG_WIN_STOPS:  cfg_stops = data;
            default: ;
        endcase
    endtask

    task automatic release_cfg();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_sample(int temp, logic [5:0] hour);
        sample_t s;
        s.temp = 8'(temp);
        s.hour = hour;
        sample_q.push_back(s);
        items_queued++;
    endtask

    // wait until every request is taken and answered, then let the pipe settle
    task automatic drain();
        while (!(items_taken == items_queued && result_due.size() == 0))
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic pick_settings(int phase);
        int sp [4];
        logic [23:0] starts, stops;
        int k;
        if (phase == 0)
        begin
            for (k = 0; k < 4; k++)
                sp[k] = -128;
            starts = '0;
            stops = '0;
        end
        else if (phase == 1)
        begin
            for (k = 0; k < 4; k++)
                sp[k] = 127;
            starts = '1;
            stops = '1;
        end
        else
        begin
            for (k = 0; k < 4; k++)
                case ($urandom_range(0, 7))
                    0: sp[k] = -128;
                    1: sp[k] = 127;
                    2: sp[k] = $urandom_range(0, 255) - 128;
                    default: sp[k] = $urandom_range(0, 50) - 10;
                endcase
            if ($urandom_range(0, 2) == 0)
                sp[3] = 127;
            if ($urandom_range(0, 4) == 0)
            begin
                starts = 24'($urandom);
                stops = 24'($urandom);
            end
            else
                for (k = 0; k < 3; k++)
                begin
                    starts[8*k +: 8] = 8'($urandom_range(0, 23));
                    stops[8*k +: 8] = 8'($urandom_range(0, 23));
                end
        end
        write_reg(REG_MODE, noisy(phase % 4, 2));
        write_reg(REG_SP_ONE, noisy(sp[0], 8));
        write_reg(REG_SP_TWO, noisy(sp[1], 8));
        write_reg(REG_SP_THREE, noisy(sp[2], 8));
        write_reg(REG_SP_LIMIT, noisy(sp[3], 8));
        write_reg(REG_WIN_STARTS, starts);
        write_reg(REG_WIN_STOPS, stops);
        if (phase == 5)
            write_reg(REG_UNUSED, 24'($urandom));
        release_cfg();
    endtask

    initial
    begin : stimulus
        int phase, n, k, hr, ref_sp, t, sent;
        bit sweep;
        logic [5:0] hour;

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: off
        queue_sample(-128, 6'h00);
        queue_sample(127, 6'h3F);
        drain();

        // low band: clear, hold, then each band and a latched relay
        write_reg(REG_SP_ONE, 24'd20);
        write_reg(REG_MODE, 24'(MODE_BAND_LOW));
        release_cfg();
        queue_sample(20, 6'h10);
        queue_sample(18, 6'h10);
        queue_sample(15, 6'h10);
        queue_sample(8, 6'h10);
        queue_sample(0, 6'h10);
        queue_sample(13, 6'h10);
        queue_sample(23, 6'h10);
        drain();

        // high band: setpoint over the limit, then widest difference
        write_reg(REG_SP_ONE, 24'd50);
        write_reg(REG_SP_LIMIT, 24'd40);
        write_reg(REG_MODE, 24'(MODE_BAND_HIGH));
        release_cfg();
        queue_sample(0, 6'h05);
        drain();
        write_reg(REG_SP_ONE, 24'd127);
        write_reg(REG_SP_LIMIT, 24'd127);
        release_cfg();
        queue_sample(-128, 6'h05);
        queue_sample(115, 6'h05);
        queue_sample(125, 6'h05);
        drain();

        // schedule: third window wraps past midnight
        write_reg(REG_SP_ONE, 24'd25);
        write_reg(REG_SP_TWO, 24'd18);
        write_reg(REG_SP_THREE, 24'h000080);
        write_reg(REG_WIN_STARTS, 24'h16_11_06);
        write_reg(REG_WIN_STOPS, 24'h02_16_09);
        write_reg(REG_MODE, 24'(MODE_SCHED));
        release_cfg();
        queue_sample(20, 6'h07);
        queue_sample(25, 6'h12);
        queue_sample(10, 6'h18);
        queue_sample(-128, 6'h23);
        queue_sample(-127, 6'h01);
        queue_sample(29, 6'h3F);
        queue_sample(15, 6'h1A);
        queue_sample(-128, 6'h20);
        drain();

        phase = 0;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick_settings(phase);
            n = $urandom_range(20, 60);
            sweep = ($urandom_range(0, 1) == 1);
            hr = $urandom_range(0, 23);
            for (k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    ref_sp = (cfg_mode == MODE_SCHED) ? win_sp[$urandom_range(0, 2)] : win_sp[0];
                    t = ref_sp - ($urandom_range(0, 40) - 8);
                    if (t < -128)
                        t = -128;
                    if (t > 127)
                        t = 127;
                end
                else
                    t = $urandom_range(0, 255) - 128;
                if (sweep)
                begin
                    hr = (hr + 1) % 24;
                    hour = bcd_hour(hr);
                end
                else if ($urandom_range(0, 7) == 0)
                    hour = 6'($urandom);
                else
                    hour = bcd_hour($urandom_range(0, 23));
                queue_sample(t, hour);
            end
            // output held off while requests keep coming, so the input stalls
            if (phase == 2 || phase == 17)
                hold_asked++;
            drain();
            sent += n;
            phase++;
        end

        drain();
        repeat (8) @(posedge clk);
        if (fault_count == 0)
            $display("staged_thermostat_scheduler_tb: done, clean");
        else
            $display("staged_thermostat_scheduler_tb: done, errors");
        $finish;
    end

endmodule
